### hw/rtl/sdrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SSTF scheduler package
// Shared sizes and item types for the SSTF disk request scheduler.
// ----------------------------------------------------------------------------
package sdrs_pkg;

   // store capacity and field widths
   localparam int MAX_REQUESTS = 64;
   localparam int CYL_W        = 16;
   localparam int DIST_W       = 16;
   localparam int TOT_W        = 22;
   localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);

   // request item
   typedef struct packed {
      logic [CYL_W-1:0] cylinder;
      logic             last_request;
   } req_type;

   // result item
   typedef struct packed {
      logic [CYL_W-1:0]  served_cylinder;
      logic [DIST_W-1:0] seek_distance;
      logic [TOT_W-1:0]  total_seek;
      logic              final_result;
      logic              requests_dropped;
   } rsp_type;

   // nearest pending request found so far in one scan
   typedef struct packed {
      logic [CYL_W-1:0]  cyl;
      logic [DIST_W-1:0] seek;
      logic [IDX_W-1:0]  idx;
   } best_type;

endpackage : sdrs_pkg
`default_nettype wire

### hw/rtl/sdrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sdrs_ram
   import sdrs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire logic [CYL_W-1:0] wr_data,
   input  wire logic [IDX_W-1:0] rd_addr,
   output logic      [CYL_W-1:0] rd_data
);

   logic [CYL_W-1:0] mem_ff [MAX_REQUESTS];
   logic [CYL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : sdrs_ram
`default_nettype wire

### hw/rtl/sdrs_nearest.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-request tracker
// Compares each pending candidate against the best so far; on equal
// distance the lower cylinder wins, on full equality the earlier entry.
// ----------------------------------------------------------------------------
module sdrs_nearest
   import sdrs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear,
   input  wire logic             cand_vld,
   input  wire logic [IDX_W-1:0] cand_idx,
   input  wire logic [CYL_W-1:0] cand_cyl,
   input  wire logic [CYL_W-1:0] head,
   output best_type              best
);

   logic              found_ff, found_in;
   best_type          best_ff, best_in;
   logic [DIST_W-1:0] cand_dist;
   logic              better;

   // distance from head and ordering test
   always_comb begin
      cand_dist = (cand_cyl > head) ? (cand_cyl - head) : (head - cand_cyl);
      better    = !found_ff || (cand_dist < best_ff.seek) ||
                  ((cand_dist == best_ff.seek) && (cand_cyl < best_ff.cyl));
   end

   always_comb begin
      found_in = found_ff;
      best_in  = best_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (cand_vld && better) begin
         found_in     = 1'b1;
         best_in.cyl  = cand_cyl;
         best_in.seek = cand_dist;
         best_in.idx  = cand_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_ff <= best_in;
   end

   assign best = best_ff;

endmodule : sdrs_nearest
`default_nettype wire

### hw/rtl/sstf_disk_request_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SSTF disk request scheduler
// Collects a batch of cylinder requests and serves them nearest-first.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* takes one request item per accept; req_ready is high only while
//    no batch is being served.
//  - An item with last_request set closes the batch. The head starts at the
//    start position held in the csr register, written via csr_write_en.
//  - For each served request the stored entries are scanned in order through the
//    single read port of the request store; once the last read data has been
//    compared, the nearest pending request is emitted.
//  - rsp_* carries one result per served request from an output register;
//    the last one has final_result set. A stalled receiver holds the
//    scheduler in its emit step until the register drains.
//  - Requests beyond the store capacity are dropped; every result of that
//    batch then has requests_dropped set.
//  - Synchronous reset empties the store, clears the start position and
//    drops any result waiting in the output register.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler
   import sdrs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_write_en,
   input  wire logic [CYL_W-1:0] csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_EMIT
   } state_type;

   state_type                state_ff, state_in;
   logic [CYL_W-1:0]         start_ff, start_in;
   logic [MAX_REQUESTS-1:0]  pending_ff, pending_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     overflow_ff, overflow_in;
   logic [CYL_W-1:0]         head_ff, head_in;
   logic [TOT_W-1:0]         sum_ff, sum_in;
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]         round_ff, round_in;
   logic                     pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]         pipe_idx_ff, pipe_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     ram_we;
   logic [CYL_W-1:0]         ram_rdata;
   logic                     best_clear;
   logic                     cand_vld;
   best_type                 best;
   logic [TOT_W-1:0]         new_sum;
   logic                     last_round;

   // request store
   sdrs_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_data.cylinder),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rdata)
   );

   // nearest tracker, fed each entry in the cycle after its read address
   assign cand_vld = pipe_vld_ff && pending_ff[pipe_idx_ff];

   sdrs_nearest u_nearest (
      .clock    (clock),
      .reset    (reset),
      .clear    (best_clear),
      .cand_vld (cand_vld),
      .cand_idx (pipe_idx_ff),
      .cand_cyl (ram_rdata),
      .head     (head_ff),
      .best     (best)
   );

   assign new_sum    = sum_ff + TOT_W'(best.seek);
   assign last_round = ((CNT_W'(round_ff) + CNT_W'(1)) == count_ff);

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      start_in     = csr_write_en ? csr_write_data : start_ff;
      pending_in   = pending_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      head_in      = head_ff;
      sum_in       = sum_ff;
      scan_idx_in  = scan_idx_ff;
      round_in     = round_ff;
      pipe_vld_in  = 1'b0;
      pipe_idx_in  = scan_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      best_clear   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (count_ff < CNT_W'(MAX_REQUESTS)) begin
                  ram_we                             = 1'b1;
                  pending_in[count_ff[IDX_W-1:0]]    = 1'b1;
                  count_in                           = count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_data.last_request) begin
                  head_in     = start_ff;
                  sum_in      = '0;
                  round_in    = '0;
                  scan_idx_in = '0;
                  best_clear  = 1'b1;
                  state_in    = ST_SCAN;
               end
            end
         end

         // issue one store read per cycle over all stored entries
         ST_SCAN: begin
            pipe_vld_in = 1'b1;
            if ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff) begin
               state_in = ST_WAIT;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end

         // last read data is compared this cycle
         ST_WAIT: begin
            state_in = ST_EMIT;
         end

         // serve the nearest request once the output register is free
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.served_cylinder  = best.cyl;
               rsp_data_in.seek_distance    = best.seek;
               rsp_data_in.total_seek       = new_sum;
               rsp_data_in.final_result     = last_round;
               rsp_data_in.requests_dropped = overflow_ff;
               sum_in                       = new_sum;
               head_in                      = best.cyl;
               pending_in[best.idx]         = 1'b0;
               best_clear                   = 1'b1;
               if (last_round) begin
                  pending_in  = '0;
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  round_in    = round_ff + IDX_W'(1);
                  scan_idx_in = '0;
                  state_in    = ST_SCAN;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         pending_ff   <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_ff     <= head_in;
      sum_ff      <= sum_in;
      scan_idx_ff <= scan_idx_in;
      round_ff    <= round_in;
      pipe_idx_ff <= pipe_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : sstf_disk_request_scheduler
`default_nettype wire
